// ===== sv/idalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// idalloc_pkg
// Shared types and constants for the free-list ID allocator.
// ----------------------------------------------------------------------------
package idalloc_pkg;

  // Size of the ID space and the first ID handed out by the counter.
  localparam int unsigned ID_COUNT = 256;
  localparam int unsigned FIRST_ID = 1;

  // The free list holds up to 256 eight-bit IDs.
  localparam int unsigned LIST_DEPTH = 256;
  localparam int unsigned LIST_AW    = 8;
  localparam int unsigned ID_W       = 8;

  // Usable IDs are 0 .. min(ID_COUNT, 256) - 1.
  localparam int unsigned ID_LIMIT = (ID_COUNT > 256) ? 256 : ID_COUNT;
  localparam logic [8:0]  ID_LIM9  = 9'(ID_LIMIT);
  localparam logic [8:0]  FIRST9   = 9'(FIRST_ID);

  // Request codes.
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_CLAIM   = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Access to the free-list memory for one cycle.
  typedef struct packed {
    logic               we;
    logic [LIST_AW-1:0] waddr;
    logic [ID_W-1:0]    wdata;
    logic               re;
    logic [LIST_AW-1:0] raddr;
  } mem_req_t;

  // Finished result offered to the output register.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    status_e         status;
  } res_t;

endpackage

// ===== sv/idalloc_ram.sv =====
// ----------------------------------------------------------------------------
// idalloc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module idalloc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/idalloc_ctrl.sv =====
// ----------------------------------------------------------------------------
// idalloc_ctrl
// Request sequencer: keeps the counter and free-list pointers and drives the
// free-list memory.
// ----------------------------------------------------------------------------
module idalloc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               req_type_i,
  input  logic [7:0]               id_value_i,
  output idalloc_pkg::mem_req_t    mem_o,
  input  logic [idalloc_pkg::ID_W-1:0] rdata_i,
  output idalloc_pkg::res_t        res_o,
  input  logic                     res_ready_i
);
  import idalloc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CLAIM = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [LIST_AW-1:0] head_q, head_d;
  logic [8:0]         count_q, count_d;
  logic [8:0]         next_q, next_d;
  logic [7:0]         tgt_q, tgt_d;
  logic [ID_W-1:0]    res_id_q, res_id_d;
  status_e            res_st_q, res_st_d;

  logic [8:0]         id9;
  logic [8:0]         gap;
  logic [9:0]         fill_after;
  logic [8:0]         next_inc;

  assign id9        = {1'b0, id_value_i};
  assign gap        = id9 - next_q;
  assign fill_after = {1'b0, count_q} + {1'b0, gap};
  assign next_inc   = next_q + 9'd1;

  // Decision logic and state updates.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    next_d     = next_q;
    tgt_d      = tgt_q;
    res_id_d   = res_id_q;
    res_st_d   = res_st_q;
    mem_o      = '0;
    in_ready_o = 1'b0;
    res_o      = '{valid: 1'b0, id: res_id_q, status: res_st_q};

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_id_d = '0;
          res_st_d = ST_OK;
          state_d  = S_DONE;
          unique case (req_type_i)
            REQ_ALLOC: begin
              if (count_q != 9'd0) begin
                // Oldest freed ID: read it from the head of the list.
                mem_o.re    = 1'b1;
                mem_o.raddr = head_q;
                head_d      = head_q + LIST_AW'(1);
                count_d     = count_q - 9'd1;
                state_d     = S_READ;
              end else if (next_q < ID_LIM9) begin
                res_id_d = next_q[7:0];
                next_d   = next_inc;
              end else begin
                res_st_d = ST_EMPTY;
              end
            end
            REQ_CLAIM: begin
              if (id9 >= ID_LIM9) begin
                res_st_d = ST_RANGE;
              end else if (id9 >= next_q) begin
                if (fill_after > 10'(LIST_DEPTH)) begin
                  res_st_d = ST_FULL;
                end else if (gap == 9'd0) begin
                  res_id_d = id_value_i;
                  next_d   = id9 + 9'd1;
                end else begin
                  // Skipped IDs are pushed one per cycle.
                  res_id_d = id_value_i;
                  tgt_d    = id_value_i;
                  state_d  = S_CLAIM;
                end
              end else begin
                res_id_d = id_value_i;
              end
            end
            REQ_RELEASE: begin
              if (id9 >= ID_LIM9) begin
                res_st_d = ST_RANGE;
              end else if (count_q >= 9'(LIST_DEPTH)) begin
                res_st_d = ST_FULL;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = head_q + count_q[LIST_AW-1:0];
                mem_o.wdata = id_value_i;
                count_d     = count_q + 9'd1;
              end
            end
            REQ_NONE: begin
              res_st_d = ST_OK;
            end
          endcase
        end
      end

      S_READ: begin
        res_id_d = rdata_i;
        state_d  = S_DONE;
      end

      S_CLAIM: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = head_q + count_q[LIST_AW-1:0];
        mem_o.wdata = next_q[7:0];
        count_d     = count_q + 9'd1;
        next_d      = next_inc;
        if (next_inc == {1'b0, tgt_q}) begin
          next_d  = {1'b0, tgt_q} + 9'd1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      next_q  <= FIRST9;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      next_q  <= next_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tgt_q    <= tgt_d;
    res_id_q <= res_id_d;
    res_st_q <= res_st_d;
  end

  // The list never holds more entries than the memory has.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 9'(LIST_DEPTH))
    else $error("free list count exceeds depth");

  // Read data is taken only in the cycle after a read was issued.
  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> $past(mem_o.re))
    else $error("read state without a preceding read");

  // A pop never targets the entry written in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.we && mem_o.re && (mem_o.waddr == mem_o.raddr)))
    else $error("read and write to the same entry");

  // A claim walk stops before the counter passes the claimed ID.
  a_claim_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLAIM) |-> (next_q < {1'b0, tgt_q}))
    else $error("claim walk overran its target");

endmodule

// ===== sv/id_allocator_with_free_fifo_core.sv =====
// ----------------------------------------------------------------------------
// id_allocator_with_free_fifo_core
// Free-list ID allocator: next-unused counter plus a FIFO of freed IDs.
// ----------------------------------------------------------------------------
// Each result passes from the sequencer's done state into the output register.
// An allocate from the free list first reads the memory, and a claim that
// skips IDs first pushes each of them onto the free list. One request is in
// flight at a time, so the input takes no new request until the last result
// has entered the output register; a result left waiting there stalls it.
// Reset clears the state, pointers, counter and output valid flag only.
// ----------------------------------------------------------------------------
module id_allocator_with_free_fifo_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] id_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] assigned_id_o,
  output logic [1:0] status_o
);
  import idalloc_pkg::*;

  mem_req_t        mem_req;
  logic [ID_W-1:0] rdata;
  res_t            res;
  logic            res_ready;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_id_q;
  logic [1:0]      out_st_q;

  // Free-list store.
  idalloc_ram #(
    .WIDTH (ID_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // Request sequencer.
  idalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .id_value_i  (id_value_i),
    .mem_o       (mem_req),
    .rdata_i     (rdata),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // The output register takes a result when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_id_q <= res.id;
      out_st_q <= res.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign assigned_id_o = out_id_q;
  assign status_o      = out_st_q;

endmodule

// ===== tb/tb_id_allocator_with_free_fifo_core.sv =====
// ----------------------------------------------------------------------------
// tb_id_allocator_with_free_fifo_core
// Self-checking testbench for the free-list ID allocator.
// ----------------------------------------------------------------------------
// A shadow of the allocator (counter, free list and pointers) predicts the
// grant and status of every accepted request. Each result transfer is checked
// against the oldest prediction. A short directed sequence comes first. Random
// phases follow: one fills the free list, one drains it until the ID space
// is used up, and one mixes all requests. Both sides idle at random, and the
// receiver once holds off for a long stretch so that the input side stalls.
// ----------------------------------------------------------------------------

// Shadow of the allocator state and the queue of grants still to come.
class id_pool_shadow;

  typedef struct packed {
    logic [7:0]           id;
    idalloc_pkg::status_e status;
  } grant_t;

  logic [7:0]  freed [idalloc_pkg::LIST_DEPTH];
  logic [7:0]  head;
  logic [8:0]  count;
  logic [8:0]  next_free;
  grant_t      pending_grants [$];
  int unsigned mismatches;

  function new();
    head       = '0;
    count      = '0;
    next_free  = idalloc_pkg::FIRST9;
    mismatches = 0;
  endfunction

  // Append an ID at the tail of the free list.
  function void push_free(logic [7:0] id);
    logic [7:0] tail;
    tail        = head + count[7:0];
    freed[tail] = id;
    count++;
  endfunction

  // Take the oldest ID from the free list.
  function logic [7:0] pop_free();
    logic [7:0] id;
    id   = freed[head];
    head = head + 8'd1;
    count--;
    return id;
  endfunction

  // Predict the result of an accepted request and update the shadow state.
  function void note_request(logic [1:0] req, logic [7:0] id);
    grant_t     g;
    logic [8:0] id9;
    int         gap;
    g.id     = '0;
    g.status = idalloc_pkg::ST_OK;
    id9      = {1'b0, id};
    case (req)
      idalloc_pkg::REQ_ALLOC: begin
        if (count != 0) begin
          g.id = pop_free();
        end else if (next_free < idalloc_pkg::ID_LIM9) begin
          g.id = next_free[7:0];
          next_free++;
        end else begin
          g.status = idalloc_pkg::ST_EMPTY;
        end
      end
      idalloc_pkg::REQ_CLAIM: begin
        if (id9 >= idalloc_pkg::ID_LIM9) begin
          g.status = idalloc_pkg::ST_RANGE;
        end else if (id9 >= next_free) begin
          // Every ID skipped by the claim goes onto the free list, lowest first.
          gap = int'(id9) - int'(next_free);
          if (int'(count) + gap > int'(idalloc_pkg::LIST_DEPTH)) begin
            g.status = idalloc_pkg::ST_FULL;
          end else begin
            while (next_free < id9) begin
              push_free(next_free[7:0]);
              next_free++;
            end
            next_free = id9 + 9'd1;
            g.id      = id;
          end
        end else begin
          // A claim below the counter leaves the free list untouched.
          g.id = id;
        end
      end
      idalloc_pkg::REQ_RELEASE: begin
        if (id9 >= idalloc_pkg::ID_LIM9) begin
          g.status = idalloc_pkg::ST_RANGE;
        end else if (int'(count) >= int'(idalloc_pkg::LIST_DEPTH)) begin
          g.status = idalloc_pkg::ST_FULL;
        end else begin
          push_free(id);
        end
      end
      default: begin
      end
    endcase
    pending_grants.push_back(g);
  endfunction

  // Compare a result transfer with the oldest prediction.
  function void check_grant(logic [7:0] id, logic [1:0] status);
    grant_t g;
    if (pending_grants.size() == 0) begin
      $error("result transfer with no request pending: assigned_id %0d status %0d",
             id, status);
      mismatches++;
    end else begin
      g = pending_grants.pop_front();
      if (id !== g.id) begin
        $error("assigned_id: expected %0d, actual %0d", g.id, id);
        mismatches++;
      end
      if (status !== g.status) begin
        $error("status: expected %0d, actual %0d", g.status, status);
        mismatches++;
      end
    end
  endfunction

  function int pending();
    return pending_grants.size();
  endfunction

  // True once both the free list and the counter are used up.
  function bit exhausted();
    return (count == 0) && (next_free >= idalloc_pkg::ID_LIM9);
  endfunction

endclass

module tb_id_allocator_with_free_fifo_core;
  import idalloc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_OFF    = 400;
  localparam int unsigned HOLD_AT     = 40;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [1:0] req_type_i    = REQ_NONE;
  logic [7:0] id_value_i    = '0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] assigned_id_o;
  logic [1:0] status_o;

  id_pool_shadow shadow = new();
  bit            calm   = 1'b0;
  int unsigned   sent   = 0;
  int unsigned   grants = 0;

  always #4 clk_i = ~clk_i;

  id_allocator_with_free_fifo_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .id_value_i    (id_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .assigned_id_o (assigned_id_o),
    .status_o      (status_o)
  );

  // Offer one request and wait for its transfer.
  task automatic offer(req_e req, logic [7:0] id);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    id_value_i <= id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.note_request(req, id);
    sent++;
    calm = ((sent / 60) % 4) == 3;
  endtask

  // Random requests; weights are in percent and the rest are unknown codes.
  // With claims_late set, claims become releases until the free list holds more
  // than 128 IDs, so that large gaps no longer fit.
  task automatic random_phase(int unsigned n, int unsigned w_alloc, int unsigned w_claim,
                              int unsigned w_release, bit claims_late, bit stop_when_dry);
    int unsigned r;
    int unsigned after_dry;
    req_e        req;
    after_dry = 0;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_alloc) begin
        req = REQ_ALLOC;
      end else if (r < w_alloc + w_claim) begin
        req = REQ_CLAIM;
      end else if (r < w_alloc + w_claim + w_release) begin
        req = REQ_RELEASE;
      end else begin
        req = REQ_NONE;
      end
      if (claims_late && req == REQ_CLAIM && shadow.count <= 9'd128) begin
        req = REQ_RELEASE;
      end
      offer(req, 8'($urandom_range(0, 255)));
      if (stop_when_dry && shadow.exhausted()) begin
        after_dry++;
        if (after_dry > 15) break;
      end
    end
  endtask

  // Take results, idling at random, with one long hold-off.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if (grants == HOLD_AT) begin
        hold = HOLD_OFF;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      shadow.check_grant(assigned_id_o, status_o);
      grants++;
    end
  end

  // Watchdog: end the run once no transfer has happened for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: counter grants, claims below, at and past the counter,
    // pops in order, repeated release, extreme IDs and unknown requests.
    offer(REQ_ALLOC, 8'd0);
    offer(REQ_CLAIM, 8'd0);
    offer(REQ_CLAIM, 8'd2);
    offer(REQ_CLAIM, 8'd6);
    offer(REQ_ALLOC, 8'd255);
    offer(REQ_RELEASE, 8'd0);
    offer(REQ_RELEASE, 8'd255);
    offer(REQ_RELEASE, 8'd4);
    offer(REQ_NONE, 8'd255);
    offer(REQ_NONE, 8'd0);
    offer(REQ_ALLOC, 8'd0);
    offer(REQ_ALLOC, 8'd0);
    offer(REQ_ALLOC, 8'd0);
    offer(REQ_ALLOC, 8'd0);
    offer(REQ_ALLOC, 8'd0);
    offer(REQ_ALLOC, 8'd0);
    offer(REQ_CLAIM, 8'd3);
    offer(REQ_CLAIM, 8'd20);
    offer(REQ_RELEASE, 8'hAA);
    offer(REQ_RELEASE, 8'h55);

    // Fill the free list until releases and wide claims are refused.
    random_phase(280, 5, 4, 90, 1'b1, 1'b0);
    // Drain the list and the counter until allocation runs dry.
    random_phase(600, 95, 2, 2, 1'b0, 1'b1);
    // Mixed traffic over the used-up ID space.
    random_phase(60, 35, 25, 35, 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/idalloc_pkg.sv
sv/idalloc_ram.sv
sv/idalloc_ctrl.sv
sv/id_allocator_with_free_fifo_core.sv
tb/tb_id_allocator_with_free_fifo_core.sv
